// File: rtl/ata_pkg.sv
// Shared constants, types and the arctangent table for the tilt angle block.
package ata_pkg;

  localparam int FRAC_BITS_DEF    = 8;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FIFO_DEPTH_DEF   = 4;

  localparam int AXIS_W    = 16;
  localparam int ANG_W     = 17;
  localparam int CFG_IDX_W = 8;
  localparam int ANG_FB    = 24;
  localparam int DIV_W     = 24;
  localparam int DMAG_W    = 16;
  localparam int PROD_W    = 25;
  localparam int CW        = 36;
  localparam int ZW        = 36;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_RAW = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RAW = CFG_IDX_W'(1);

  localparam logic signed [AXIS_W-1:0] MIN_RAW_RESET = 16'sd265;
  localparam logic signed [AXIS_W-1:0] MAX_RAW_RESET = 16'sd402;

  localparam logic signed [PROD_W-1:0] MAP_SCALE  = 25'sd180;
  localparam logic signed [PROD_W-1:0] MAP_OFFSET = 25'sd90;

  localparam longint PI_Q60 = 64'sh3243F6A8885A308D;
  localparam longint PI_Q30 = 64'sh00000000C90FDAA2;

  typedef struct packed {
    logic signed [AXIS_W-1:0] mx;
    logic signed [AXIS_W-1:0] my;
    logic signed [AXIS_W-1:0] mz;
    logic                     err;
  } ata_item_t;

  // shift-subtract quotient of non-negative operands, elaboration only
  function automatic longint udiv(longint n, longint d);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((n >> b) & longint'(1));
      if (r >= d) begin
        r = r - d;
        q = q | (longint'(1) << b);
      end
    end
    return q;
  endfunction

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic longint atan_deg(int i);
    longint r60;
    longint r40;
    longint t;
    int     e;
    r60 = 0;
    if (i == 0) begin
      r60 = PI_Q60 >>> 2;
    end else begin
      for (int k = 0; k < 64; k++) begin
        e = 60 - i * (2 * k + 1);
        if (e >= 0) begin
          t = udiv(longint'(1) << e, longint'(2 * k + 1));
          r60 = ((k & 1) != 0) ? r60 - t : r60 + t;
        end
      end
    end
    r40 = (r60 + (longint'(1) << 19)) >>> 20;
    return udiv(r40 * 180 * 16384 + (PI_Q30 >>> 1), PI_Q30);
  endfunction

endpackage

// File: rtl/ata_fifo.sv
// Small register queue between the mapping front end and the angle back end.
module ata_fifo #(
  parameter int WIDTH = 49,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      count;
  logic             push;
  logic             pop;

  assign in_ready  = (count < (AW+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_data;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

endmodule

// File: rtl/ata_front.sv
// Front end: takes samples and maps each axis with a pipelined restoring divider.
module ata_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ata_pkg::AXIS_W-1:0]   accel_x,
  input  logic signed [ata_pkg::AXIS_W-1:0]   accel_y,
  input  logic signed [ata_pkg::AXIS_W-1:0]   accel_z,
  input  logic signed [ata_pkg::AXIS_W-1:0]   min_raw,
  input  logic signed [ata_pkg::AXIS_W-1:0]   max_raw,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ata_pkg::ata_item_t                  out_item
);

  localparam int DW = ata_pkg::DIV_W;
  localparam int MW = ata_pkg::DMAG_W;
  localparam int PW = ata_pkg::PROD_W;
  localparam int AXW = ata_pkg::AXIS_W;

  logic                 en;
  logic                 vld  [DW+1];
  logic                 err  [DW+1];
  logic [DW-1:0]        work [3][DW+1];
  logic [MW-1:0]        rem  [3][DW+1];
  logic                 neg  [3][DW+1];
  logic [MW-1:0]        dmag;
  logic signed [AXW:0]  dsub;
  logic signed [AXW-1:0] axis [3];
  logic signed [AXW-1:0] mapped [3];

  assign axis[0] = accel_x;
  assign axis[1] = accel_y;
  assign axis[2] = accel_z;

  assign en        = !vld[DW] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[DW];
  assign dsub      = {max_raw[AXW-1], max_raw} - {min_raw[AXW-1], min_raw};

  always_ff @(posedge clk) begin
    dmag <= dsub[AXW] ? MW'(-dsub) : dsub[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= DW; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_valid;
      for (int s = 1; s <= DW; s++) begin
        vld[s] <= vld[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err[0] <= (min_raw == max_raw);
      for (int s = 1; s <= DW; s++) begin
        err[s] <= err[s-1];
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [AXW:0]  diff;
    logic signed [PW-1:0] prod;

    assign diff = {axis[a][AXW-1], axis[a]} - {min_raw[AXW-1], min_raw};
    assign prod = PW'(diff) * ata_pkg::MAP_SCALE;

    always_ff @(posedge clk) begin
      if (en) begin
        work[a][0] <= prod[PW-1] ? DW'(-prod) : prod[DW-1:0];
        rem[a][0]  <= '0;
        neg[a][0]  <= prod[PW-1] ^ dsub[AXW];
      end
    end

    for (genvar s = 0; s < DW; s++) begin : g_stage
      logic [MW:0]   trial;
      logic          fits;
      logic [MW:0]   diffr;

      assign trial = {rem[a][s], work[a][s][DW-1]};
      assign diffr = trial - {1'b0, dmag};
      assign fits  = (trial >= {1'b0, dmag});

      always_ff @(posedge clk) begin
        if (en) begin
          rem[a][s+1]  <= fits ? diffr[MW-1:0] : trial[MW-1:0];
          work[a][s+1] <= {work[a][s][DW-2:0], fits};
          neg[a][s+1]  <= neg[a][s];
        end
      end
    end

    logic signed [PW-1:0] quot;
    logic signed [PW-1:0] q;
    logic signed [PW-1:0] m;

    assign quot      = signed'({1'b0, work[a][DW]});
    assign q         = neg[a][DW] ? -quot : quot;
    assign m         = q - ata_pkg::MAP_OFFSET;
    assign mapped[a] = m[AXW-1:0];
  end

  assign out_item.mx  = mapped[0];
  assign out_item.my  = mapped[1];
  assign out_item.mz  = mapped[2];
  assign out_item.err = err[DW];

endmodule

// File: rtl/ata_cordic.sv
// One pipelined CORDIC vectoring lane: atan2(ya, xa) + 180 degrees.
module ata_cordic #(
  parameter int FRAC_BITS    = ata_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = ata_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [ata_pkg::AXIS_W:0] ya,
  input  logic signed [ata_pkg::AXIS_W:0] xa,
  output logic [ata_pkg::ANG_W-1:0]       angle
);

  localparam int CW = ata_pkg::CW;
  localparam int ZW = ata_pkg::ZW;
  localparam int FB = ata_pkg::ANG_FB;
  localparam int SH = FB - FRAC_BITS;
  localparam logic signed [ZW-1:0] Z90  = ZW'(90)  <<< FB;
  localparam logic signed [ZW-1:0] Z180 = ZW'(180) <<< FB;
  localparam logic signed [ZW-1:0] Z360 = ZW'(360) <<< FB;

  logic signed [CW-1:0] x  [CORDIC_STEPS+1];
  logic signed [CW-1:0] y  [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z  [CORDIC_STEPS+1];
  logic                 zf [CORDIC_STEPS+1];

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;

  assign xs = CW'(xa) <<< 16;
  assign ys = CW'(ya) <<< 16;

  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (xa == '0) && (ya == '0);
      if (xa[ata_pkg::AXIS_W]) begin
        if (!ya[ata_pkg::AXIS_W]) begin
          x[0] <= ys;
          y[0] <= -xs;
          z[0] <= Z90;
        end else begin
          x[0] <= -ys;
          y[0] <= xs;
          z[0] <= -Z90;
        end
      end else begin
        x[0] <= xs;
        y[0] <= ys;
        z[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ATAN = ZW'(ata_pkg::atan_deg(i));
    logic signed [CW-1:0] xsh;
    logic signed [CW-1:0] ysh;

    assign xsh = x[i] >>> i;
    assign ysh = y[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (!y[i][CW-1]) begin
          x[i+1] <= x[i] + ysh;
          y[i+1] <= y[i] - xsh;
          z[i+1] <= z[i] + ATAN;
        end else begin
          x[i+1] <= x[i] - ysh;
          y[i+1] <= y[i] + xsh;
          z[i+1] <= z[i] - ATAN;
        end
      end
    end
  end

  logic signed [ZW-1:0] tot;
  logic signed [ZW-1:0] clp;
  logic [ZW-1:0]        rnd;

  always_comb begin
    tot = zf[CORDIC_STEPS] ? Z180 : z[CORDIC_STEPS] + Z180;
    if (tot < 0) begin
      clp = '0;
    end else if (tot > Z360) begin
      clp = Z360;
    end else begin
      clp = tot;
    end
    rnd = unsigned'(clp) + (ZW'(1) << (SH - 1));
  end

  assign angle = ata_pkg::ANG_W'(rnd >> SH);

endmodule

// File: rtl/ata_back.sv
// Back end: three CORDIC lanes turn mapped axes into roll, pitch and yaw.
module ata_back #(
  parameter int FRAC_BITS    = ata_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = ata_pkg::CORDIC_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ata_pkg::ata_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ata_pkg::ANG_W-1:0]   roll_deg,
  output logic [ata_pkg::ANG_W-1:0]   pitch_deg,
  output logic [ata_pkg::ANG_W-1:0]   yaw_deg,
  output logic                        range_error
);

  localparam int AXW = ata_pkg::AXIS_W;

  logic en;
  logic vld [CORDIC_STEPS+1];
  logic err [CORDIC_STEPS+1];
  logic signed [AXW:0] nx;
  logic signed [AXW:0] ny;
  logic signed [AXW:0] nz;
  logic [ata_pkg::ANG_W-1:0] roll_a;
  logic [ata_pkg::ANG_W-1:0] pitch_a;
  logic [ata_pkg::ANG_W-1:0] yaw_a;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign nx = -{in_item.mx[AXW-1], in_item.mx};
  assign ny = -{in_item.my[AXW-1], in_item.my};
  assign nz = -{in_item.mz[AXW-1], in_item.mz};

  ata_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .en(en), .ya(ny), .xa(nz), .angle(roll_a)
  );
  ata_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .en(en), .ya(nx), .xa(nz), .angle(pitch_a)
  );
  ata_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .en(en), .ya(ny), .xa(nx), .angle(yaw_a)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      err[0] <= in_item.err;
      for (int s = 1; s <= CORDIC_STEPS; s++) begin
        err[s] <= err[s-1];
      end
      roll_deg    <= err[CORDIC_STEPS] ? '0 : roll_a;
      pitch_deg   <= err[CORDIC_STEPS] ? '0 : pitch_a;
      yaw_deg     <= err[CORDIC_STEPS] ? '0 : yaw_a;
      range_error <= err[CORDIC_STEPS];
    end
    if (rst) begin
      out_valid <= 1'b0;
      for (int s = 0; s <= CORDIC_STEPS; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_valid;
      for (int s = 1; s <= CORDIC_STEPS; s++) begin
        vld[s] <= vld[s-1];
      end
      out_valid <= vld[CORDIC_STEPS];
    end
  end

endmodule

// File: rtl/accel_tilt_angles.sv
// Top level: tilt angles from one three-axis accelerometer sample.
// One sample per clock is accepted while the output does not stall, and one result
// per sample comes out in order; a sample passes the 25 divider stages of the axis
// mapping, the queue register, CORDIC_STEPS+1 vectoring stages and the output
// register. Each axis is mapped as (v-min)*180/(max-min)-90, then roll, pitch and
// yaw are atan2(-a,-b)+180 degrees with FRAC_BITS fraction bits.
// The user must write min_raw and max_raw through the cfg port only while no
// transaction is in flight; the block itself does not enforce this. Equal
// bounds set range_error and force the angles to zero.
module accel_tilt_angles #(
  parameter int FRAC_BITS    = ata_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = ata_pkg::CORDIC_STEPS_DEF,
  parameter int FIFO_DEPTH   = ata_pkg::FIFO_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ata_pkg::AXIS_W-1:0]    accel_x,
  input  logic signed [ata_pkg::AXIS_W-1:0]    accel_y,
  input  logic signed [ata_pkg::AXIS_W-1:0]    accel_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ata_pkg::ANG_W-1:0]            roll_deg,
  output logic [ata_pkg::ANG_W-1:0]            pitch_deg,
  output logic [ata_pkg::ANG_W-1:0]            yaw_deg,
  output logic                                 range_error,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ata_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ata_pkg::AXIS_W-1:0]           cfg_data
);

  logic signed [ata_pkg::AXIS_W-1:0] min_raw;
  logic signed [ata_pkg::AXIS_W-1:0] max_raw;
  logic               f_valid;
  logic               f_ready;
  ata_pkg::ata_item_t f_item;
  logic               q_valid;
  logic               q_ready;
  ata_pkg::ata_item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_raw <= ata_pkg::MIN_RAW_RESET;
      max_raw <= ata_pkg::MAX_RAW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ata_pkg::REG_MIN_RAW: min_raw <= signed'(cfg_data);
        ata_pkg::REG_MAX_RAW: max_raw <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  ata_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .min_raw(min_raw), .max_raw(max_raw),
    .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
  );

  ata_fifo #(.WIDTH($bits(ata_pkg::ata_item_t)), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_item)
  );

  ata_back #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .roll_deg(roll_deg), .pitch_deg(pitch_deg), .yaw_deg(yaw_deg),
    .range_error(range_error)
  );

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> roll_deg == '0 && pitch_deg == '0 && yaw_deg == '0)
    else $error("range error result carries nonzero angle");

  a_cfg_min: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == ata_pkg::REG_MIN_RAW
    |=> min_raw == signed'($past(cfg_data)))
    else $error("min_raw write lost");

  a_cfg_max: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == ata_pkg::REG_MAX_RAW
    |=> max_raw == signed'($past(cfg_data)))
    else $error("max_raw write lost");
`endif

endmodule
